### hw/rtl/acfp_pkg.sv
// acfp_pkg: shared types, character codes and command constants for the
// downlink command frame parser; no dependencies
`default_nettype none

package acfp_pkg;

   localparam int unsigned WIN_LEN = 7;
   localparam int unsigned FILL_W  = $clog2(WIN_LEN);

   // character codes
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_B      = 8'h42;
   localparam logic [7:0] CHAR_F      = 8'h46;
   localparam logic [7:0] CHAR_G      = 8'h47;
   localparam logic [7:0] CHAR_L      = 8'h4C;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_O      = 8'h4F;
   localparam logic [7:0] CHAR_Q      = 8'h51;
   localparam logic [7:0] CHAR_T      = 8'h54;
   localparam logic [7:0] CHAR_W      = 8'h57;

   // command limits and scale factors
   localparam logic signed [7:0]  GNSS_MAX  = 8'(6 * 4);
   localparam logic signed [7:0]  SLOW_MAX  = 8'(6 * 2);
   localparam logic signed [7:0]  FIX_MIN   = 8'sd1;
   localparam logic signed [7:0]  FIX_MAX   = 8'(10);
   localparam logic signed [15:0] GNSS_STEP = 16'(15 * 60);
   localparam logic signed [15:0] SLOW_STEP = 16'(30 * 60);

   localparam int unsigned BOOT_LEN = 4;

   typedef enum logic [1:0] {
      TARGET_GNSS  = 2'd0,
      TARGET_WAVE  = 2'd1,
      TARGET_THERM = 2'd2,
      TARGET_FIXES = 2'd3
   } target_type;

   // a complete window in the framed form, handed to the decoder
   typedef struct packed {
      logic       framed;
      logic [7:0] tag0;
      logic [7:0] tag1;
      logic [7:0] tag2;
      logic [7:0] val_hi;
      logic [7:0] val_lo;
   } frame_type;

   typedef struct packed {
      logic               valid;
      target_type         target;
      logic signed [15:0] value;
   } update_type;

   function automatic logic [7:0] boot_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0:    ch = CHAR_B;
         2'd1:    ch = CHAR_O;
         2'd2:    ch = CHAR_O;
         default: ch = CHAR_T;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/acfp_window.sv
// acfp_window: seven-byte sliding window with fill count and frame detection
// depends on acfp_pkg
`default_nettype none

module acfp_window (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic [7:0]         data_byte,
   input  wire logic               message_start,
   output acfp_pkg::frame_type     frame
);
   import acfp_pkg::*;

   logic [7:0]        win_ff [WIN_LEN];
   logic [7:0]        win_in [WIN_LEN];
   logic [7:0]        written [WIN_LEN];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] fill_eff;
   logic              full;
   logic              framed;

   always_comb begin
      fill_eff = message_start ? '0 : fill_ff;
      for (int i = 0; i < WIN_LEN; i++) begin
         written[i] = (FILL_W'(i) == fill_eff) ? data_byte : win_ff[i];
      end
      full   = (fill_eff == FILL_W'(WIN_LEN - 1));
      framed = full && (win_ff[0] == CHAR_DOLLAR) && (data_byte == CHAR_SEMI);

      for (int i = 0; i < WIN_LEN; i++) begin
         win_in[i] = written[i];
      end
      if (full && !framed) begin
         // drop the oldest byte
         for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_in[i] = written[i + 1];
         end
         fill_in = FILL_W'(WIN_LEN - 1);
      end else if (framed) begin
         fill_in = '0;
      end else begin
         fill_in = fill_eff + 1'b1;
      end
   end

   always_comb begin
      frame.framed = framed;
      frame.tag0   = win_ff[1];
      frame.tag1   = win_ff[2];
      frame.tag2   = win_ff[3];
      frame.val_hi = win_ff[4];
      frame.val_lo = win_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else if (enable) begin
         fill_ff <= fill_in;
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/acfp_boot.sv
// acfp_boot: checks whether the first four bytes of a message spell BOOT
// depends on acfp_pkg
`default_nettype none

module acfp_boot (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       enable,
   input  wire logic [7:0] data_byte,
   input  wire logic       message_start,
   output      logic       reboot
);
   import acfp_pkg::*;

   localparam int unsigned POS_W = $clog2(BOOT_LEN + 1);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pos_eff;
   logic             match_ff;
   logic             match_in;
   logic             match_eff;

   always_comb begin
      pos_eff   = message_start ? '0 : pos_ff;
      match_eff = message_start ? 1'b1 : match_ff;
      pos_in    = pos_eff;
      match_in  = match_eff;
      reboot    = 1'b0;
      if (pos_eff < POS_W'(BOOT_LEN)) begin
         match_in = match_eff && (data_byte == boot_char(pos_eff[1:0]));
         pos_in   = pos_eff + 1'b1;
         reboot   = match_in && (pos_eff == POS_W'(BOOT_LEN - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= 1'b1;
      end else if (enable) begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/acfp_cmd.sv
// acfp_cmd: decodes the two value characters and the tag of a framed window
// depends on acfp_pkg
`default_nettype none

module acfp_cmd (
   input  wire acfp_pkg::frame_type  frame,
   output      acfp_pkg::update_type update
);
   import acfp_pkg::*;

   logic               dig_hi;
   logic               dig_lo;
   logic               space_hi;
   logic [3:0]         val_hi;
   logic [3:0]         val_lo;
   logic signed [7:0]  v;
   logic signed [15:0] v_ext;
   logic signed [15:0] gnss_value;
   logic signed [15:0] slow_value;
   logic               tag_gfq;
   logic               tag_wfq;
   logic               tag_tfq;
   logic               tag_gml;

   always_comb begin
      dig_hi   = (frame.val_hi >= CHAR_ZERO) && (frame.val_hi <= CHAR_NINE);
      dig_lo   = (frame.val_lo >= CHAR_ZERO) && (frame.val_lo <= CHAR_NINE);
      // space, tab, lf, vt, ff, cr
      space_hi = (frame.val_hi == CHAR_SPACE) ||
                 ((frame.val_hi >= CHAR_TAB) && (frame.val_hi <= CHAR_CR));
      val_hi   = frame.val_hi[3:0];
      val_lo   = frame.val_lo[3:0];

      priority if (dig_hi) begin
         if (dig_lo) begin
            v = signed'(({4'b0, val_hi} << 3) + ({4'b0, val_hi} << 1) + {4'b0, val_lo});
         end else begin
            v = signed'({4'b0, val_hi});
         end
      end else if (space_hi || frame.val_hi == CHAR_PLUS) begin
         v = dig_lo ? signed'({4'b0, val_lo}) : 8'sd0;
      end else if (frame.val_hi == CHAR_MINUS) begin
         v = dig_lo ? -signed'({4'b0, val_lo}) : 8'sd0;
      end else begin
         v = 8'sd0;
      end

      v_ext      = 16'(v);
      gnss_value = 16'(v_ext * GNSS_STEP);
      slow_value = 16'(v_ext * SLOW_STEP);

      tag_gfq = (frame.tag0 == CHAR_G) && (frame.tag1 == CHAR_F) && (frame.tag2 == CHAR_Q);
      tag_wfq = (frame.tag0 == CHAR_W) && (frame.tag1 == CHAR_F) && (frame.tag2 == CHAR_Q);
      tag_tfq = (frame.tag0 == CHAR_T) && (frame.tag1 == CHAR_F) && (frame.tag2 == CHAR_Q);
      tag_gml = (frame.tag0 == CHAR_G) && (frame.tag1 == CHAR_M) && (frame.tag2 == CHAR_L);

      update.valid  = 1'b0;
      update.target = TARGET_GNSS;
      update.value  = '0;
      if (frame.framed) begin
         priority if (tag_gfq && v <= GNSS_MAX) begin
            update.valid  = 1'b1;
            update.target = TARGET_GNSS;
            update.value  = gnss_value;
         end else if (tag_wfq && v <= SLOW_MAX) begin
            update.valid  = 1'b1;
            update.target = TARGET_WAVE;
            update.value  = slow_value;
         end else if (tag_tfq && v <= SLOW_MAX) begin
            update.valid  = 1'b1;
            update.target = TARGET_THERM;
            update.value  = slow_value;
         end else if (tag_gml && v >= FIX_MIN && v <= FIX_MAX) begin
            update.valid  = 1'b1;
            update.target = TARGET_FIXES;
            update.value  = v_ext;
         end else begin
            update.valid  = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ascii_command_frame_parser_unit.sv
// ascii_command_frame_parser_unit: downlink command frame parser, top level
// pipeline: the item is held in the input register, then decoded as it moves to the result
// register, which drives rsp_; rsp_stall holds both stages
// throughput: one item per cycle while rsp_stall does not hold the result register
// exactly one result item per input item, in order
// reset (synchronous, active high) empties both stages, clears the window and
// fill count and restarts the boot check
`default_nettype none

module ascii_command_frame_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input item channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_message_start,
   // result item channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_update_valid,
   output      logic [1:0]  rsp_update_target,
   output      logic signed [15:0] rsp_update_value,
   output      logic        rsp_reboot_request
);
   import acfp_pkg::*;

   // input register stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // result register stage
   logic               out_valid_ff;
   logic               out_update_valid_ff;
   target_type         out_target_ff;
   logic signed [15:0] out_value_ff;
   logic               out_reboot_ff;

   logic       advance;
   logic       process;
   frame_type  frame;
   update_type update;
   logic       reboot;

   // the result register frees up when empty or when its item is taken
   assign advance   = !out_valid_ff || !rsp_stall;
   // the item in the input register is worked on as it moves to the result
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // window state and frame detection
   acfp_window u_window (
      .clock         (clock),
      .reset         (reset),
      .enable        (process),
      .data_byte     (in_byte_ff),
      .message_start (in_start_ff),
      .frame         (frame)
   );

   // tag lookup, value decode and scaling
   acfp_cmd u_cmd (
      .frame  (frame),
      .update (update)
   );

   // boot prefix check, runs alongside the window
   acfp_boot u_boot (
      .clock         (clock),
      .reset         (reset),
      .enable        (process),
      .data_byte     (in_byte_ff),
      .message_start (in_start_ff),
      .reboot        (reboot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_message_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         out_update_valid_ff <= update.valid;
         out_target_ff       <= update.target;
         out_value_ff        <= update.value;
         out_reboot_ff       <= reboot;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_update_valid   = out_update_valid_ff;
   assign rsp_update_target  = out_target_ff;
   assign rsp_update_value   = out_value_ff;
   assign rsp_reboot_request = out_reboot_ff;

endmodule

`default_nettype wire
